// ===== sv/rsve_pkg.sv =====
// ----------------------------------------------------------------------------
// rsve_pkg: shared types and constants of the ribbon vertex expander
// Operation codes and request/response bundles of the shared iterative unit,
// and configuration register indexes.
// ----------------------------------------------------------------------------
package rsve_pkg;

	// configuration register indexes
	localparam logic [7:0] REG_CAMERA_X    = 8'd0;
	localparam logic [7:0] REG_CAMERA_Y    = 8'd1;
	localparam logic [7:0] REG_CAMERA_Z    = 8'd2;
	localparam logic [7:0] REG_POINT_COUNT = 8'd3;

	// operations of the shared unit
	typedef enum logic [1:0] {
		OP_MUL      = 2'd0,
		OP_DIV_NORM = 2'd1,
		OP_DIV_INT  = 2'd2,
		OP_SQRT     = 2'd3
	} iter_op_t;

	// request from the sequencer
	typedef struct packed {
		logic        start;
		iter_op_t    op;
		logic [63:0] opa;
		logic [31:0] opb;
	} iter_req_t;

	// response to the sequencer
	typedef struct packed {
		logic        done;
		logic [63:0] res;
	} iter_rsp_t;

endpackage

// ===== sv/ribbon_strip_vertex_expander_core.sv =====
// ----------------------------------------------------------------------------
// ribbon_strip_vertex_expander_core: camera-facing ribbon vertex expander
// Takes ribbon points and emits a plus and a minus edge vertex for each point,
// offset along the unit side vector by half the point width.
// ----------------------------------------------------------------------------
// Points arrive one per transfer; the block holds the previous point and,
// once the next one is known, emits the plus and minus edge vertices of the
// held point (and of the final point too, when it arrives). The input is not
// ready while a point is worked on. Products, roots and quotients all come
// from one shared unit: the sequencer issues each multiply, square root,
// normalizing or integer divide and waits for its result. A normalization
// pre-shifts the vector, then sums three squares, takes the square root and
// does three divides. A ribbon's first point is only held, a point with
// point_count below 2 emits no vertices; while the output is stalled, the
// sequencer waits. Offsets are rounded half away from zero and vertex
// coordinates saturate. degenerate travels in tuser, the final vertex carries tlast.
// ----------------------------------------------------------------------------
module ribbon_strip_vertex_expander_core #(
	parameter int MAX_POINTS = 1024
) (
	input  logic         clk,
	input  logic         arst_n,
	// configuration write channel
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [7:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	// points in
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// point_x, point_y, point_z, point_width, point_color
	input  logic [143:0] s_axis_tdata,
	// vertices out
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// vert_x, vert_y, vert_z, tex_u, tex_v, vert_color, zero pad
	output logic [151:0] m_axis_tdata,
	// degenerate
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);

	localparam logic [16:0] MaxPts = 17'(MAX_POINTS);

	typedef enum logic [23:0] {
		S_IDLE    = 24'h000001,
		S_DIR     = 24'h000002,
		S_DIRDONE = 24'h000004,
		S_EF      = 24'h000008,
		S_CR0     = 24'h000010,
		S_XA      = 24'h000020,
		S_XB      = 24'h000040,
		S_XC      = 24'h000080,
		S_SIDE    = 24'h000100,
		S_OA      = 24'h000200,
		S_OB      = 24'h000400,
		S_EU      = 24'h000800,
		S_OUT0    = 24'h001000,
		S_HOLD0   = 24'h002000,
		S_HOLD1   = 24'h004000,
		S_WAIT    = 24'h008000,
		S_ULOAD   = 24'h010000,
		S_USHIFT  = 24'h020000,
		S_USQ     = 24'h040000,
		S_UACC    = 24'h080000,
		S_USQRT   = 24'h100000,
		S_ULEN    = 24'h200000,
		S_UDIV    = 24'h400000,
		S_UQ      = 24'h800000
	} state_t;

	state_t state_q, wret_q, uret_q;

	// configuration
	logic signed [31:0] cam_x_q, cam_y_q, cam_z_q;
	logic [10:0]        count_q;

	// held and current point
	logic signed [31:0] held_x_q, held_y_q, held_z_q;
	logic [15:0]        held_w_q;
	logic [31:0]        held_c_q;
	logic [10:0]        pidx_q;
	logic signed [31:0] cur_x_q, cur_y_q, cur_z_q;
	logic [15:0]        cur_w_q;
	logic [31:0]        cur_c_q;

	// per-item control
	logic [10:0]        cnt_q;
	logic [10:0]        idx0_q;
	logic               final_q;
	logic               pass_q;
	logic [1:0]         ci_q;

	// vectors
	logic signed [31:0] dir_q [3];
	logic signed [31:0] fw_q  [3];
	logic signed [31:0] uni_q [3];
	logic signed [31:0] off_q [3];
	logic signed [63:0] vec_q [3];
	logic [63:0]        m_q   [3];
	logic [2:0]         neg_q;
	logic [63:0]        sum_q;
	logic [31:0]        len_q;
	logic signed [63:0] prod_q;
	logic               dir_ok_q, ok_q, unz_q;
	logic [15:0]        u16_q;

	// output register
	logic               ovalid_q;
	logic [151:0]       odata_q;
	logic               ouser_q, olast_q;

	rsve_pkg::iter_req_t req;
	rsve_pkg::iter_rsp_t rsp;

	rsve_iter u_iter (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	function automatic logic [1:0] nxt3(logic [1:0] i);
		case (i)
			2'd0:    return 2'd1;
			2'd1:    return 2'd2;
			default: return 2'd0;
		endcase
	endfunction

	function automatic logic [63:0] mag64(logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

	function automatic logic [31:0] mag32(logic signed [31:0] v);
		return v[31] ? 32'(-v) : 32'(v);
	endfunction

	function automatic logic [31:0] sat_add(logic signed [31:0] p, logic signed [31:0] o,
		logic sub);
		logic signed [32:0] s;
		s = sub ? (33'(p) - 33'(o)) : (33'(p) + 33'(o));
		if (s[32] != s[31]) return s[32] ? 32'h8000_0000 : 32'h7fff_ffff;
		return s[31:0];
	endfunction

	// point under emission
	logic signed [31:0] px, py, pz;
	logic [15:0]        pw;
	logic [31:0]        pc;
	logic [10:0]        pidx_emit;
	logic [1:0]         cp, cq;
	logic [10:0]        cnt_m1;
	logic [26:0]        unum;
	logic [63:0]        rnd;
	logic [31:0]        offq;
	logic [10:0]        cnt_in;
	logic               shift_any, m_zero;

	assign px        = pass_q ? cur_x_q : held_x_q;
	assign py        = pass_q ? cur_y_q : held_y_q;
	assign pz        = pass_q ? cur_z_q : held_z_q;
	assign pw        = pass_q ? cur_w_q : held_w_q;
	assign pc        = pass_q ? cur_c_q : held_c_q;
	assign cnt_m1    = cnt_q - 11'd1;
	assign pidx_emit = pass_q ? cnt_m1 : idx0_q;
	assign unum      = {pidx_emit, 16'b0} - {16'b0, pidx_emit};
	assign cp        = nxt3(ci_q);
	assign cq        = nxt3(cp);
	assign rnd       = rsp.res + 64'h2000_0000;
	assign offq      = rnd[61:30];
	assign cnt_in    = ({6'b0, count_q} > MaxPts) ? MaxPts[10:0] : count_q;
	assign shift_any = (|m_q[0][63:30]) | (|m_q[1][63:30]) | (|m_q[2][63:30]);
	assign m_zero    = (m_q[0] == '0) && (m_q[1] == '0) && (m_q[2] == '0);

	// operand selection for the shared unit
	always_comb begin
		req       = '0;
		req.op    = rsve_pkg::OP_MUL;
		case (state_q)
			S_USQ: begin
				req.start = 1'b1;
				req.opa   = {32'b0, m_q[ci_q][31:0]};
				req.opb   = m_q[ci_q][31:0];
			end
			S_USQRT: begin
				req.start = 1'b1;
				req.op    = rsve_pkg::OP_SQRT;
				req.opa   = sum_q;
			end
			S_UDIV: begin
				req.start = 1'b1;
				req.op    = rsve_pkg::OP_DIV_NORM;
				req.opa   = m_q[ci_q];
				req.opb   = len_q;
			end
			S_XA: begin
				req.start = 1'b1;
				req.opa   = {32'b0, dir_q[cp]};
				req.opb   = fw_q[cq];
			end
			S_XB: begin
				req.start = 1'b1;
				req.opa   = {32'b0, dir_q[cq]};
				req.opb   = fw_q[cp];
			end
			S_OA: begin
				req.start = 1'b1;
				req.opa   = {32'b0, mag32(uni_q[ci_q])};
				req.opb   = {9'b0, pw, 7'b0};
			end
			S_EU: begin
				req.start = 1'b1;
				req.op    = rsve_pkg::OP_DIV_INT;
				req.opa   = {37'b0, unum};
				req.opb   = {21'b0, cnt_m1};
			end
			default: begin
				req.start = 1'b0;
			end
		endcase
	end

	// configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_x_q <= '0;
			cam_y_q <= '0;
			cam_z_q <= '0;
			count_q <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				rsve_pkg::REG_CAMERA_X:    cam_x_q <= cfg_data;
				rsve_pkg::REG_CAMERA_Y:    cam_y_q <= cfg_data;
				rsve_pkg::REG_CAMERA_Z:    cam_z_q <= cfg_data;
				rsve_pkg::REG_POINT_COUNT: count_q <= cfg_data[10:0];
				default: ;
			endcase
		end
	end

	// sequencer and ribbon state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			wret_q   <= S_IDLE;
			uret_q   <= S_IDLE;
			held_x_q <= '0;
			held_y_q <= '0;
			held_z_q <= '0;
			held_w_q <= '0;
			held_c_q <= '0;
			pidx_q   <= '0;
			ovalid_q <= 1'b0;
			pass_q   <= 1'b0;
			final_q  <= 1'b0;
			ci_q     <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (s_axis_tvalid) begin
						cur_x_q <= s_axis_tdata[31:0];
						cur_y_q <= s_axis_tdata[63:32];
						cur_z_q <= s_axis_tdata[95:64];
						cur_w_q <= s_axis_tdata[111:96];
						cur_c_q <= s_axis_tdata[143:112];
						cnt_q   <= cnt_in;
						pass_q  <= 1'b0;
						if (cnt_in < 11'd2) begin
							pidx_q <= '0;
						end else if (pidx_q == '0) begin
							pidx_q   <= 11'd1;
							held_x_q <= s_axis_tdata[31:0];
							held_y_q <= s_axis_tdata[63:32];
							held_z_q <= s_axis_tdata[95:64];
							held_w_q <= s_axis_tdata[111:96];
							held_c_q <= s_axis_tdata[143:112];
						end else if (pidx_q >= cnt_in - 11'd1) begin
							final_q <= 1'b1;
							idx0_q  <= (pidx_q - 11'd1 > cnt_in - 11'd1) ?
								cnt_in - 11'd1 : pidx_q - 11'd1;
							pidx_q  <= '0;
							state_q <= S_DIR;
						end else begin
							final_q <= 1'b0;
							idx0_q  <= pidx_q - 11'd1;
							pidx_q  <= pidx_q + 11'd1;
							state_q <= S_DIR;
						end
					end
				end
				// direction from current to held point
				S_DIR: begin
					vec_q[0] <= 64'(held_x_q) - 64'(cur_x_q);
					vec_q[1] <= 64'(held_y_q) - 64'(cur_y_q);
					vec_q[2] <= 64'(held_z_q) - 64'(cur_z_q);
					uret_q   <= S_DIRDONE;
					state_q  <= S_ULOAD;
				end
				S_DIRDONE: begin
					dir_q    <= uni_q;
					dir_ok_q <= unz_q;
					state_q  <= S_EF;
				end
				// camera-to-point vector
				S_EF: begin
					vec_q[0] <= 64'(px) - 64'(cam_x_q);
					vec_q[1] <= 64'(py) - 64'(cam_y_q);
					vec_q[2] <= 64'(pz) - 64'(cam_z_q);
					uret_q   <= S_CR0;
					state_q  <= S_ULOAD;
				end
				S_CR0: begin
					fw_q    <= uni_q;
					ok_q    <= dir_ok_q & unz_q;
					ci_q    <= '0;
					state_q <= S_XA;
				end
				// cross product, one component per pass
				S_XA: begin
					wret_q  <= S_XB;
					state_q <= S_WAIT;
				end
				S_XB: begin
					prod_q  <= rsp.res;
					wret_q  <= S_XC;
					state_q <= S_WAIT;
				end
				S_XC: begin
					vec_q[ci_q] <= prod_q - $signed(rsp.res);
					if (ci_q == 2'd2) begin
						uret_q  <= S_SIDE;
						state_q <= S_ULOAD;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= S_XA;
					end
				end
				S_SIDE: begin
					ok_q    <= ok_q & unz_q;
					ci_q    <= '0;
					state_q <= S_OA;
				end
				// offsets: side times half width, rounded
				S_OA: begin
					wret_q  <= S_OB;
					state_q <= S_WAIT;
				end
				S_OB: begin
					off_q[ci_q] <= uni_q[ci_q][31] ? -$signed(offq) : $signed(offq);
					if (ci_q == 2'd2) begin
						state_q <= S_EU;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= S_OA;
					end
				end
				S_EU: begin
					wret_q  <= S_OUT0;
					state_q <= S_WAIT;
				end
				// vertex output
				S_OUT0: begin
					u16_q    <= rsp.res[15:0];
					odata_q  <= {7'b0, pc, 1'b0, rsp.res[15:0],
						sat_add(pz, off_q[2], 1'b0), sat_add(py, off_q[1], 1'b0),
						sat_add(px, off_q[0], 1'b0)};
					ouser_q  <= ~ok_q;
					olast_q  <= 1'b0;
					ovalid_q <= 1'b1;
					state_q  <= S_HOLD0;
				end
				S_HOLD0: begin
					if (m_axis_tready) begin
						odata_q <= {7'b0, pc, 1'b1, u16_q,
							sat_add(pz, off_q[2], 1'b1), sat_add(py, off_q[1], 1'b1),
							sat_add(px, off_q[0], 1'b1)};
						olast_q <= pass_q;
						state_q <= S_HOLD1;
					end
				end
				S_HOLD1: begin
					if (m_axis_tready) begin
						ovalid_q <= 1'b0;
						if (!pass_q && final_q) begin
							pass_q  <= 1'b1;
							state_q <= S_EF;
						end else begin
							held_x_q <= cur_x_q;
							held_y_q <= cur_y_q;
							held_z_q <= cur_z_q;
							held_w_q <= cur_w_q;
							held_c_q <= cur_c_q;
							state_q  <= S_IDLE;
						end
					end
				end
				S_WAIT: begin
					if (rsp.done) state_q <= wret_q;
				end
				// normalization: magnitudes and signs
				S_ULOAD: begin
					for (int k = 0; k < 3; k++) begin
						m_q[k]   <= mag64(vec_q[k]);
						neg_q[k] <= vec_q[k][63];
					end
					state_q <= S_USHIFT;
				end
				// pre-shift until every magnitude is below 2^30
				S_USHIFT: begin
					if (m_zero) begin
						for (int k = 0; k < 3; k++) uni_q[k] <= '0;
						unz_q   <= 1'b0;
						state_q <= uret_q;
					end else if (shift_any) begin
						for (int k = 0; k < 3; k++) m_q[k] <= m_q[k] >> 1;
					end else begin
						sum_q   <= '0;
						ci_q    <= '0;
						state_q <= S_USQ;
					end
				end
				S_USQ: begin
					wret_q  <= S_UACC;
					state_q <= S_WAIT;
				end
				S_UACC: begin
					sum_q <= sum_q + rsp.res;
					if (ci_q == 2'd2) begin
						state_q <= S_USQRT;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= S_USQ;
					end
				end
				S_USQRT: begin
					wret_q  <= S_ULEN;
					state_q <= S_WAIT;
				end
				S_ULEN: begin
					len_q   <= rsp.res[31:0];
					ci_q    <= '0;
					state_q <= S_UDIV;
				end
				S_UDIV: begin
					wret_q  <= S_UQ;
					state_q <= S_WAIT;
				end
				S_UQ: begin
					uni_q[ci_q] <= neg_q[ci_q] ? -$signed(rsp.res[31:0]) : $signed(rsp.res[31:0]);
					if (ci_q == 2'd2) begin
						unz_q   <= 1'b1;
						state_q <= uret_q;
					end else begin
						ci_q    <= ci_q + 2'd1;
						state_q <= S_UDIV;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata  = odata_q;
	assign m_axis_tuser  = ouser_q;
	assign m_axis_tlast  = olast_q;

	// a result from the shared unit only arrives while the sequencer waits
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> state_q == S_WAIT)
		else $error("shared unit finished outside a wait");

	// no vertex pending while new points are taken
	a_idle_no_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tready |-> !m_axis_tvalid)
		else $error("output pending while idle");

	// the ribbon's last vertex is a minus-edge vertex
	a_last_minus: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tlast) |-> m_axis_tdata[112])
		else $error("last vertex on plus edge");

	// the plus-edge vertex is followed by its minus-edge twin
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tready && !m_axis_tdata[112]) |=>
		(m_axis_tvalid && m_axis_tdata[112]))
		else $error("minus-edge vertex missing");

endmodule

// ===== sv/rsve_iter.sv =====
// ----------------------------------------------------------------------------
// rsve_iter: shared arithmetic unit
// One signed 32x32 multiply, a radix-2 restoring divider with a 32-bit
// quotient, and a bitwise integer square root of a 64-bit value.
// ----------------------------------------------------------------------------
module rsve_iter (
	input  logic                clk,
	input  logic                arst_n,
	input  rsve_pkg::iter_req_t req,
	output rsve_pkg::iter_rsp_t rsp
);

	logic                busy_q;
	logic                done_q;
	logic [5:0]          steps_q;
	rsve_pkg::iter_op_t  op_q;
	logic [63:0]         s_q;
	logic [63:0]         r_q;
	logic [63:0]         b_q;
	logic [31:0]         q_q;
	logic [31:0]         div_q;

	// divider step
	logic [32:0] rem2;
	logic        dge;
	logic [32:0] rem_sub;
	logic [31:0] rem_n;
	assign rem2    = {s_q[31:0], q_q[31]};
	assign dge     = rem2 >= {1'b0, div_q};
	assign rem_sub = rem2 - {1'b0, div_q};
	assign rem_n   = dge ? rem_sub[31:0] : rem2[31:0];

	// square root step
	logic [63:0] sq_t;
	logic        sge;
	assign sq_t = r_q + b_q;
	assign sge  = s_q >= sq_t;

	// signed product
	logic signed [63:0] prod;
	assign prod = $signed(req.opa[31:0]) * $signed(req.opb);

	// control and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			done_q  <= 1'b0;
			steps_q <= '0;
			op_q    <= rsve_pkg::OP_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				op_q <= req.op;
				case (req.op)
					rsve_pkg::OP_MUL: begin
						done_q <= 1'b1;
					end
					rsve_pkg::OP_DIV_NORM: begin
						busy_q  <= 1'b1;
						steps_q <= 6'd31;
					end
					rsve_pkg::OP_DIV_INT: begin
						busy_q  <= 1'b1;
						steps_q <= 6'd27;
					end
					default: begin
						busy_q  <= 1'b1;
						steps_q <= 6'd32;
					end
				endcase
			end else if (busy_q) begin
				steps_q <= steps_q - 6'd1;
				if (steps_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			div_q <= req.opb;
			case (req.op)
				rsve_pkg::OP_MUL: begin
					r_q <= prod;
				end
				rsve_pkg::OP_DIV_NORM: begin
					s_q <= {34'b0, req.opa[30:1]};
					q_q <= {req.opa[0], 31'b0};
				end
				rsve_pkg::OP_DIV_INT: begin
					s_q <= '0;
					q_q <= {req.opa[26:0], 5'b0};
				end
				default: begin
					s_q <= req.opa;
					r_q <= '0;
					b_q <= 64'h4000_0000_0000_0000;
				end
			endcase
		end else if (busy_q) begin
			if (op_q == rsve_pkg::OP_SQRT) begin
				s_q <= sge ? s_q - sq_t : s_q;
				r_q <= sge ? (r_q >> 1) + b_q : r_q >> 1;
				b_q <= b_q >> 2;
			end else begin
				s_q <= {32'b0, rem_n};
				q_q <= {q_q[30:0], dge};
			end
		end
	end

	assign rsp.done = done_q;
	assign rsp.res  = (op_q == rsve_pkg::OP_DIV_NORM || op_q == rsve_pkg::OP_DIV_INT)
		? {32'b0, q_q} : r_q;

endmodule
